FILE: rtl/core/imu_complementary_tilt_filter_assert.svh
// assertion macros used by the checker file
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// checked only outside reset
`define ICTF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ictf assertion failed");

// checked at every edge, reset included
`define ICTF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ictf assertion failed around reset");

`endif

FILE: rtl/core/ictf_pkg.sv
`timescale 1ns / 1ps
package ictf_pkg;

   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STEPS    = 16;
   localparam int STEP_W          = $clog2(CORDIC_STEPS);

   // cordic datapath
   localparam int XY_W  = 34;
   localparam int Z_W   = 36;
   localparam int CR_SH = 30 - ANGLE_FRAC_BITS;
   localparam int ZR_W  = Z_W - CR_SH + 2;
   localparam int ANG_W = ANGLE_FRAC_BITS + 5;
   localparam logic signed [Z_W-1:0] PI_Q30 = 36'sd3373259426;

   // serial multiplier
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 24;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam logic [MUL_B_W-1:0] RATE_Q56 = 24'd9600322;

   // square root
   localparam int SQ_W       = 32;
   localparam int RAD_W      = 60;
   localparam int ROOT_W     = 30;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // estimate update
   localparam int EST_W    = 24;
   localparam int DELTA_SH = 56 - ANGLE_FRAC_BITS;
   localparam int DL_W     = MUL_P_W - DELTA_SH + 2;
   localparam int BLEND_SH = 16;
   localparam int BL_W     = MUL_P_W - BLEND_SH + 2;
   localparam int DIFF_W   = 32;

   localparam int CSR_W = 20;
   localparam int LIM_W = 15;

   typedef enum logic [1:0] {
      CSR_BLEND  = 2'd0,
      CSR_PERIOD = 2'd1,
      CSR_TILT   = 2'd2,
      CSR_PAN    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] tilt_angle;
      logic signed [15:0] pan_angle;
      logic [31:0]        frame_number;
   } rsp_type;

   // arctangent of 2^-i in Q30, truncated
   function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         default: v = 30'h0;
      endcase
      atan_q30 = {{(Z_W-30){1'b0}}, v};
   endfunction

endpackage

FILE: rtl/core/ictf_if.sv
`timescale 1ns / 1ps
interface ictf_req_if;
   logic              valid;
   logic              ready;
   ictf_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ictf_rsp_if;
   logic              valid;
   logic              ready;
   ictf_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/ictf_mul.sv
`timescale 1ns / 1ps
module ictf_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ictf_pkg::MUL_A_W-1:0] mcand,
   input  logic [ictf_pkg::MUL_B_W-1:0]        mplier,
   output logic                                done,
   output logic signed [ictf_pkg::MUL_P_W-1:0] prod
);

   logic signed [ictf_pkg::MUL_P_W-1:0] acc_ff;
   logic signed [ictf_pkg::MUL_P_W-1:0] mcand_ff;
   logic [ictf_pkg::MUL_B_W-1:0]        mplier_ff;
   logic [ictf_pkg::MUL_CNT_W-1:0]      cnt_ff;
   logic                                busy_ff;
   logic                                done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == ictf_pkg::MUL_CNT_W'(ictf_pkg::MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one multiplier bit per cycle, lsb first
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= ictf_pkg::MUL_P_W'(mcand);
         mplier_ff <= mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

FILE: rtl/core/ictf_sqrt.sv
`timescale 1ns / 1ps
module ictf_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ictf_pkg::SQ_W-1:0]       radicand,
   output logic                            done,
   output logic [ictf_pkg::ROOT_W-1:0]     root
);

   logic [ictf_pkg::RAD_W-1:0]      rem_ff;
   logic [ictf_pkg::RAD_W-1:0]      bit_ff;
   logic [ictf_pkg::RAD_W:0]        res_ff;
   logic [ictf_pkg::RAD_W:0]        trial;
   logic [ictf_pkg::ROOT_CNT_W-1:0] cnt_ff;
   logic                            busy_ff;
   logic                            done_ff;

   assign trial = res_ff + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == ictf_pkg::ROOT_CNT_W'(ictf_pkg::ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // two radicand bits per cycle, restoring
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {radicand, {(ictf_pkg::RAD_W - ictf_pkg::SQ_W){1'b0}}};
         res_ff <= '0;
         bit_ff <= ictf_pkg::RAD_W'(1) << (2 * (ictf_pkg::ROOT_W - 1));
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff <= rem_ff - trial[ictf_pkg::RAD_W-1:0];
            res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ictf_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/core/ictf_cordic.sv
`timescale 1ns / 1ps
module ictf_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [ictf_pkg::XY_W-1:0]  x_in,
   input  logic signed [ictf_pkg::XY_W-1:0]  y_in,
   output logic                              done,
   output logic signed [ictf_pkg::ANG_W-1:0] angle
);

   logic signed [ictf_pkg::XY_W-1:0] x_ff;
   logic signed [ictf_pkg::XY_W-1:0] y_ff;
   logic signed [ictf_pkg::XY_W-1:0] dx;
   logic signed [ictf_pkg::XY_W-1:0] dy;
   logic signed [ictf_pkg::Z_W-1:0]  z_ff;
   logic signed [ictf_pkg::Z_W-1:0]  at;
   logic signed [ictf_pkg::ZR_W-1:0] zr_ext;
   logic signed [ictf_pkg::ZR_W-1:0] zr_sum;
   logic [ictf_pkg::STEP_W-1:0]      step_ff;
   logic                             busy_ff;
   logic                             done_ff;
   logic                             zero_ff;

   always_comb begin
      dx     = y_ff >>> step_ff;
      dy     = x_ff >>> step_ff;
      at     = ictf_pkg::atan_q30(5'(step_ff));
      // round half up into the angle format
      zr_ext = ictf_pkg::ZR_W'(signed'(z_ff[ictf_pkg::Z_W-1:ictf_pkg::CR_SH-1]));
      zr_sum = zr_ext + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == ictf_pkg::STEP_W'(ictf_pkg::CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (x_in == '0) && (y_in == '0);
         // left half plane: turn by pi first
         if (x_in[ictf_pkg::XY_W-1]) begin
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= y_in[ictf_pkg::XY_W-1] ? -ictf_pkg::PI_Q30 : ictf_pkg::PI_Q30;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         if (!y_ff[ictf_pkg::XY_W-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end
      end
   end

   assign done  = done_ff;
   assign angle = zero_ff ? '0 : ictf_pkg::ANG_W'(zr_sum >>> 1);

endmodule

FILE: rtl/core/imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps
// channel  dir  beat contents
// req      in   accel_x, accel_y, accel_z, gyro_x, gyro_y
// rsp      out  tilt_angle, pan_angle, frame_number
// csr      in   write enable, register index, write data
//
// one sample at a time; req_ready is high only while the block is free
// first sample after reset: a 30-step root and two 16-step cordic passes
// later samples also run the 24-bit serial multiplier six times
// a finished beat waits in the rsp register; the next sample may enter meanwhile
// synchronous reset clears control state and restores register defaults
module imu_complementary_tilt_filter (
   input  logic                          clock,
   input  logic                          reset,
   ictf_req_if.sink                      req,
   ictf_rsp_if.source                    rsp,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [ictf_pkg::CSR_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_ROOT,
      ST_PITCH,
      ST_GYRO,
      ST_RATE,
      ST_MIX,
      ST_EMIT
   } state_type;

   state_type state_ff;

   logic [15:0]                          blend_ff;
   logic [ictf_pkg::CSR_W-1:0]           period_ff;
   logic [ictf_pkg::LIM_W-1:0]           tilt_lim_ff;
   logic [ictf_pkg::LIM_W-1:0]           pan_lim_ff;

   ictf_pkg::req_type                    in_ff;
   logic [ictf_pkg::SQ_W-1:0]            sq_y_ff;
   logic [ictf_pkg::SQ_W-1:0]            sq_z_ff;
   logic [ictf_pkg::SQ_W-1:0]            sq_y_in;
   logic [ictf_pkg::SQ_W-1:0]            sq_z_in;
   logic [ictf_pkg::SQ_W-1:0]            sq_sum;

   logic signed [ictf_pkg::ANG_W-1:0]    acc_roll_ff;
   logic signed [ictf_pkg::ANG_W-1:0]    acc_pitch_ff;
   logic signed [ictf_pkg::EST_W-1:0]    roll_ff;
   logic signed [ictf_pkg::EST_W-1:0]    pitch_ff;
   logic                                 first_ff;
   logic [31:0]                          frame_ff;
   logic                                 axis_ff;

   logic                                 sq_go_ff;
   logic                                 sq_done;
   logic [ictf_pkg::ROOT_W-1:0]          root;

   logic                                 cor_go_ff;
   logic signed [ictf_pkg::XY_W-1:0]     cor_x_ff;
   logic signed [ictf_pkg::XY_W-1:0]     cor_y_ff;
   logic                                 cor_done;
   logic signed [ictf_pkg::ANG_W-1:0]    cor_angle;

   logic                                 mul_go_ff;
   logic signed [ictf_pkg::MUL_A_W-1:0]  mul_a_ff;
   logic [ictf_pkg::MUL_B_W-1:0]         mul_b_ff;
   logic                                 mul_done;
   logic signed [ictf_pkg::MUL_P_W-1:0]  mul_prod;

   logic signed [ictf_pkg::EST_W-1:0]    est_sel;
   logic signed [ictf_pkg::ANG_W-1:0]    acc_sel;
   logic signed [ictf_pkg::DL_W-1:0]     dl_ext;
   logic signed [ictf_pkg::DL_W-1:0]     dl_sum;
   logic signed [ictf_pkg::DL_W-1:0]     delta;
   logic signed [ictf_pkg::DIFF_W-1:0]   diff;
   logic signed [ictf_pkg::BL_W-1:0]     bl_ext;
   logic signed [ictf_pkg::BL_W-1:0]     bl_sum;
   logic signed [ictf_pkg::EST_W-1:0]    blend_est;

   ictf_pkg::rsp_type                    rsp_ff;
   logic                                 rsp_valid_ff;

   function automatic logic signed [ictf_pkg::EST_W-1:0] sat_est(
      input logic signed [ictf_pkg::BL_W-1:0] v
   );
      logic signed [ictf_pkg::BL_W-1:0] hi;
      logic signed [ictf_pkg::BL_W-1:0] lo;
      hi = ictf_pkg::BL_W'({1'b0, {(ictf_pkg::EST_W-1){1'b1}}});
      lo = -hi - ictf_pkg::BL_W'(1);
      if (v > hi) begin
         sat_est = {1'b0, {(ictf_pkg::EST_W-1){1'b1}}};
      end else if (v < lo) begin
         sat_est = {1'b1, {(ictf_pkg::EST_W-1){1'b0}}};
      end else begin
         sat_est = ictf_pkg::EST_W'(v);
      end
   endfunction

   function automatic logic signed [15:0] clamp_lim(
      input logic signed [ictf_pkg::EST_W-1:0] v,
      input logic [ictf_pkg::LIM_W-1:0]        lim
   );
      logic signed [ictf_pkg::EST_W:0] w;
      logic signed [ictf_pkg::EST_W:0] l;
      w = ictf_pkg::EST_W'(1) == 0 ? '0 : (ictf_pkg::EST_W+1)'(v);
      l = signed'((ictf_pkg::EST_W+1)'(lim));
      if (w > l) begin
         clamp_lim = 16'(l);
      end else if (w < -l) begin
         clamp_lim = 16'(-l);
      end else begin
         clamp_lim = 16'(w);
      end
   endfunction

   always_comb begin
      sq_y_in = req.payload.accel_y * req.payload.accel_y;
      sq_z_in = req.payload.accel_z * req.payload.accel_z;
      sq_sum  = sq_y_ff + sq_z_ff;

      est_sel = axis_ff ? pitch_ff : roll_ff;
      acc_sel = axis_ff ? acc_pitch_ff : acc_roll_ff;

      // gyro step, rounded half up
      dl_ext = ictf_pkg::DL_W'(signed'(mul_prod[ictf_pkg::MUL_P_W-1:ictf_pkg::DELTA_SH-1]));
      dl_sum = dl_ext + 1'b1;
      delta  = dl_sum >>> 1;
      diff   = ictf_pkg::DIFF_W'(est_sel) + ictf_pkg::DIFF_W'(delta)
               - ictf_pkg::DIFF_W'(acc_sel);

      // alpha*(est+delta-acc) + acc*2^16, rounded half up by 16
      bl_ext = ictf_pkg::BL_W'(signed'(mul_prod[ictf_pkg::MUL_P_W-1:ictf_pkg::BLEND_SH-1]));
      bl_sum = bl_ext + (ictf_pkg::BL_W'(acc_sel) <<< 1) + 1'b1;
      blend_est = sat_est(bl_sum >>> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blend_ff     <= 16'd64225;
         period_ff    <= ictf_pkg::CSR_W'(10000);
         tilt_lim_ff  <= ictf_pkg::LIM_W'(25736);
         pan_lim_ff   <= ictf_pkg::LIM_W'(25736);
         roll_ff      <= '0;
         pitch_ff     <= '0;
         first_ff     <= 1'b1;
         frame_ff     <= '0;
         axis_ff      <= 1'b0;
         sq_go_ff     <= 1'b0;
         cor_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_go_ff  <= 1'b0;
         cor_go_ff <= 1'b0;
         mul_go_ff <= 1'b0;

         if (csr_write_en) begin
            case (csr_index)
               ictf_pkg::CSR_BLEND:  blend_ff    <= csr_wdata[15:0];
               ictf_pkg::CSR_PERIOD: period_ff   <= csr_wdata;
               ictf_pkg::CSR_TILT:   tilt_lim_ff <= csr_wdata[ictf_pkg::LIM_W-1:0];
               ictf_pkg::CSR_PAN:    pan_lim_ff  <= csr_wdata[ictf_pkg::LIM_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  in_ff    <= req.payload;
                  sq_y_ff  <= sq_y_in;
                  sq_z_ff  <= sq_z_in;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               // root and roll angle run side by side
               sq_go_ff  <= 1'b1;
               cor_go_ff <= 1'b1;
               cor_x_ff  <= ictf_pkg::XY_W'(in_ff.accel_z) <<< 14;
               cor_y_ff  <= ictf_pkg::XY_W'(in_ff.accel_y) <<< 14;
               state_ff  <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_done) begin
                  acc_roll_ff <= cor_angle;
                  cor_go_ff   <= 1'b1;
                  cor_x_ff    <= ictf_pkg::XY_W'(root);
                  cor_y_ff    <= -(ictf_pkg::XY_W'(in_ff.accel_x) <<< 14);
                  state_ff    <= ST_PITCH;
               end
            end
            ST_PITCH: begin
               if (cor_done) begin
                  acc_pitch_ff <= cor_angle;
                  if (first_ff) begin
                     roll_ff  <= sat_est(ictf_pkg::BL_W'(acc_roll_ff));
                     pitch_ff <= sat_est(ictf_pkg::BL_W'(cor_angle));
                     state_ff <= ST_EMIT;
                  end else begin
                     axis_ff   <= 1'b0;
                     mul_a_ff  <= ictf_pkg::MUL_A_W'(in_ff.gyro_x);
                     mul_b_ff  <= ictf_pkg::MUL_B_W'(period_ff);
                     mul_go_ff <= 1'b1;
                     state_ff  <= ST_GYRO;
                  end
               end
            end
            ST_GYRO: begin
               if (mul_done) begin
                  mul_a_ff  <= mul_prod[ictf_pkg::MUL_A_W-1:0];
                  mul_b_ff  <= ictf_pkg::RATE_Q56;
                  mul_go_ff <= 1'b1;
                  state_ff  <= ST_RATE;
               end
            end
            ST_RATE: begin
               if (mul_done) begin
                  mul_a_ff  <= ictf_pkg::MUL_A_W'(diff);
                  mul_b_ff  <= ictf_pkg::MUL_B_W'(blend_ff);
                  mul_go_ff <= 1'b1;
                  state_ff  <= ST_MIX;
               end
            end
            ST_MIX: begin
               if (mul_done) begin
                  if (!axis_ff) begin
                     roll_ff   <= blend_est;
                     axis_ff   <= 1'b1;
                     mul_a_ff  <= ictf_pkg::MUL_A_W'(in_ff.gyro_y);
                     mul_b_ff  <= ictf_pkg::MUL_B_W'(period_ff);
                     mul_go_ff <= 1'b1;
                     state_ff  <= ST_GYRO;
                  end else begin
                     pitch_ff <= blend_est;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff.tilt_angle   <= clamp_lim(roll_ff, tilt_lim_ff);
                  rsp_ff.pan_angle    <= clamp_lim(pitch_ff, pan_lim_ff);
                  rsp_ff.frame_number <= frame_ff + 32'd1;
                  frame_ff            <= frame_ff + 32'd1;
                  rsp_valid_ff        <= 1'b1;
                  first_ff            <= 1'b0;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   ictf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_go_ff),
      .radicand (sq_sum),
      .done     (sq_done),
      .root     (root)
   );

   ictf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_go_ff),
      .x_in  (cor_x_ff),
      .y_in  (cor_y_ff),
      .done  (cor_done),
      .angle (cor_angle)
   );

   ictf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_go_ff),
      .mcand  (mul_a_ff),
      .mplier (mul_b_ff),
      .done   (mul_done),
      .prod   (mul_prod)
   );

endmodule

FILE: rtl/core/ictf_checker.sv
`timescale 1ns / 1ps
`include "imu_complementary_tilt_filter_assert.svh"
module ictf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_frame
);

   logic [31:0] last_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_frame_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_frame_ff <= rsp_frame;
      end
   end

   // only one sample in the datapath
   `ICTF_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready)
   `ICTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame))
   // every accepted beat is numbered one above the previous one
   `ICTF_ASSERT(a_frame_step, clock, reset, rsp_valid && rsp_ready |-> rsp_frame == last_frame_ff + 32'd1)
   `ICTF_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid && req_ready)

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_frame (rsp.payload.frame_number)
);
